[rtl/pfh_pkg.sv]
// Package for the piecewise fuzzy hash engine: constants, word types and the
// helper functions for the block trigger test and the base64 symbol lookup.
// No dependencies.
package pfh_pkg;

   // Rolling window
   localparam int WINDOW_LEN = 7;
   localparam int POS_W      = $clog2(WINDOW_LEN);
   localparam int XOR_SHIFT  = 5;

   // FNV-1 constants
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_MULT  = 32'd16777619;

   // Item modes
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_END  = 1'b1;

   // Signature parts
   localparam logic PART_ONE = 1'b0;
   localparam logic PART_TWO = 1'b1;

   // Base64 alphabet anchors (ASCII)
   localparam logic [6:0] CHAR_UPPER_A = 7'd65;
   localparam logic [6:0] CHAR_LOWER_A = 7'd97;
   localparam logic [6:0] CHAR_DIGIT_0 = 7'd48;
   localparam logic [6:0] CHAR_PLUS    = 7'd43;
   localparam logic [6:0] CHAR_SLASH   = 7'd47;

   typedef logic [4:0] shift_type;

   // Word handed from the rolling stage to the block hash stage
   typedef struct packed {
      logic        mode;
      logic [7:0]  data_byte;
      logic [31:0] roll;
   } roll_word_type;

   // One result word
   typedef struct packed {
      logic       which_part;
      logic [6:0] symbol_char;
      logic       last;
   } rsp_entry_type;

   // Up to two result words produced by one item
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type first;
      rsp_entry_type second;
   } result_pair_type;

   // Add two residues modulo 3
   function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   // 32-bit value modulo 3: base-4 digits each weigh 1 mod 3, reduced as a tree
   function automatic logic [1:0] mod3_32(input logic [31:0] v);
      logic [1:0] l0 [16];
      logic [1:0] l1 [8];
      logic [1:0] l2 [4];
      logic [1:0] l3 [2];
      for (int i = 0; i < 16; i++) begin
         l0[i] = (v[2*i +: 2] == 2'd3) ? 2'd0 : v[2*i +: 2];
      end
      for (int i = 0; i < 8; i++) begin
         l1[i] = mod3_add(l0[2*i], l0[2*i+1]);
      end
      for (int i = 0; i < 4; i++) begin
         l2[i] = mod3_add(l1[2*i], l1[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         l3[i] = mod3_add(l2[2*i], l2[2*i+1]);
      end
      return mod3_add(l3[0], l3[1]);
   endfunction

   // roll mod (3 << k) == (3 << k) - 1, for k up to 32:
   // low k bits all ones and (roll >> k) mod 3 == 2
   function automatic logic block_hit(input logic [31:0] roll, input logic [5:0] k);
      logic [31:0] low_mask;
      logic        low_ok;
      logic [31:0] upper;
      low_mask = ~(32'hFFFF_FFFF << k);
      low_ok   = &(roll | ~low_mask);
      upper    = roll >> k;
      return low_ok && (mod3_32(upper) == 2'd2);
   endfunction

   // Base64 character of a six-bit index
   function automatic logic [6:0] b64_char(input logic [5:0] idx);
      logic [6:0] ix;
      logic [6:0] ch;
      ix = {1'b0, idx};
      priority if (ix < 7'd26) begin
         ch = CHAR_UPPER_A + ix;
      end else if (ix < 7'd52) begin
         ch = CHAR_LOWER_A + ix - 7'd26;
      end else if (ix < 7'd62) begin
         ch = CHAR_DIGIT_0 + ix - 7'd52;
      end else if (ix == 7'd62) begin
         ch = CHAR_PLUS;
      end else begin
         ch = CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

[rtl/pfh_req_if.sv]
// Input channel of the fuzzy hash engine: one file byte or an end marker
// per word. No dependencies.
interface pfh_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

[rtl/pfh_rsp_if.sv]
// Result channel of the fuzzy hash engine: one signature character per word.
// No dependencies.
interface pfh_rsp_if;
   logic       valid;
   logic       ready;
   logic       which_part;
   logic [6:0] symbol_char;
   logic       last;

   modport source (output valid, output which_part, output symbol_char, output last,
                   input ready);
   modport sink   (input valid, input which_part, input symbol_char, input last,
                   output ready);
endinterface

[rtl/piecewise_fuzzy_hash_engine_core.sv]
// Piecewise fuzzy hash engine, top level: rolling stage, block hash stage
// and output buffer. Depends on pfh_pkg, pfh_req_if, pfh_rsp_if and submodules.
//
// Takes one file byte per word and produces the two parts of a
// context-triggered piecewise signature as base64 characters, part one at
// block size 3 << block_shift and part two at twice that. An end word flushes
// any part with pending bytes and clears all hash state; block_shift keeps its
// value. One word is accepted every cycle unless the output buffer holds the
// input back. Results pass through the rolling stage register and the output
// buffer, which holds one item's results; an item that gives two characters
// holds back the next item and the input while both its characters are held.
// The per-byte loop is the FNV multiply in the block hash stage, run in
// parallel with the trigger test. block_shift is written through
// csr_write_enable/csr_write_data; the user must write it only while idle,
// which the block itself does not enforce.
module piecewise_fuzzy_hash_engine_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  pfh_pkg::shift_type csr_write_data,
   pfh_req_if.sink            req_chan,
   pfh_rsp_if.source          rsp_chan
);
   import pfh_pkg::*;

   shift_type       block_shift_ff;
   logic            accept;
   logic            a_valid;
   logic            b_go;
   logic            can_load;
   roll_word_type   a_word;
   result_pair_type pair;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff <= '0;
      end else if (csr_write_enable) begin
         block_shift_ff <= csr_write_data;
      end
   end

   // Handshake: the rolling stage frees up whenever the block stage takes its word
   assign b_go           = a_valid && can_load;
   assign req_chan.ready = !a_valid || b_go;
   assign accept         = req_chan.valid && req_chan.ready;

   pfh_roll u_roll (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_mode (req_chan.mode),
      .in_byte (req_chan.data_byte),
      .taken   (b_go),
      .valid   (a_valid),
      .word    (a_word)
   );

   pfh_block u_block (
      .clock       (clock),
      .reset       (reset),
      .go          (b_go),
      .word        (a_word),
      .block_shift (block_shift_ff),
      .pair        (pair)
   );

   pfh_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (b_go),
      .pair     (pair),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/pfh_roll.sv]
// Rolling hash stage: window, sums and shift-xor, updated on each accepted data
// word and cleared by an accepted end word. Depends on pfh_pkg.
module pfh_roll (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  in_mode,
   input  logic [7:0]            in_byte,
   input  logic                  taken,
   output logic                  valid,
   output pfh_pkg::roll_word_type word
);
   import pfh_pkg::*;

   logic [31:0]      window_sum_ff, window_sum_in;
   logic [31:0]      weighted_ff, weighted_in;
   logic [31:0]      shift_xor_ff, shift_xor_in;
   logic [7:0]       byte_window_ff [WINDOW_LEN];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   roll_word_type    word_ff, word_in;
   logic [31:0]      b32;

   // Next rolling state for a data byte
   always_comb begin
      b32           = {24'd0, in_byte};
      window_sum_in = window_sum_ff + b32 - {24'd0, byte_window_ff[pos_ff]};
      weighted_in   = weighted_ff - window_sum_ff + (32'(WINDOW_LEN) * b32);
      shift_xor_in  = (shift_xor_ff << XOR_SHIFT) ^ b32;
      pos_in        = (pos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;
      word_in.mode      = in_mode;
      word_in.data_byte = in_byte;
      word_in.roll      = window_sum_in + weighted_in + shift_xor_in;
   end

   // Stage valid: set on accept, cleared when the next stage takes the word
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Rolling state; an end word returns it to its cleared value
   always_ff @(posedge clock) begin
      if (reset || (accept && in_mode == MODE_END)) begin
         window_sum_ff <= '0;
         weighted_ff   <= '0;
         shift_xor_ff  <= '0;
         pos_ff        <= '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            byte_window_ff[i] <= '0;
         end
      end else if (accept) begin
         window_sum_ff          <= window_sum_in;
         weighted_ff            <= weighted_in;
         shift_xor_ff           <= shift_xor_in;
         pos_ff                 <= pos_in;
         byte_window_ff[pos_ff] <= in_byte;
      end
   end

   // Payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign valid = valid_ff;
   assign word  = word_ff;

endmodule

[rtl/pfh_block.sv]
// Block hash stage: two FNV-1 hashes, trigger test and flush on end words.
// Depends on pfh_pkg.
module pfh_block (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  pfh_pkg::roll_word_type  word,
   input  pfh_pkg::shift_type      block_shift,
   output pfh_pkg::result_pair_type pair
);
   import pfh_pkg::*;

   logic [31:0] fnv1_ff, fnv1_in;
   logic [31:0] fnv2_ff, fnv2_in;
   logic        pend1_ff, pend1_in;
   logic        pend2_ff, pend2_in;
   logic [31:0] b32;
   logic [31:0] prod1, prod2;
   logic [5:0]  k1, k2;
   logic        hit1, hit2;
   logic        v0, v1;
   logic [31:0] h0, h1;

   // Hash absorb and trigger test run side by side
   always_comb begin
      b32   = {24'd0, word.data_byte};
      prod1 = (fnv1_ff * FNV_MULT) ^ b32;
      prod2 = (fnv2_ff * FNV_MULT) ^ b32;
      k1    = {1'b0, block_shift};
      k2    = k1 + 6'd1;
      hit1  = block_hit(word.roll, k1);
      hit2  = block_hit(word.roll, k2);
   end

   // Candidate results and next hash state
   always_comb begin
      if (word.mode == MODE_DATA) begin
         v0       = hit1;
         h0       = prod1;
         v1       = hit2;
         h1       = prod2;
         fnv1_in  = hit1 ? FNV_BASIS : prod1;
         fnv2_in  = hit2 ? FNV_BASIS : prod2;
         pend1_in = !hit1;
         pend2_in = !hit2;
      end else begin
         v0       = pend1_ff;
         h0       = fnv1_ff;
         v1       = pend2_ff;
         h1       = fnv2_ff;
         fnv1_in  = FNV_BASIS;
         fnv2_in  = FNV_BASIS;
         pend1_in = 1'b0;
         pend2_in = 1'b0;
      end
   end

   // Pack results; part one always ahead of part two
   always_comb begin
      pair.count              = {v0 & v1, v0 ^ v1};
      pair.second.which_part  = PART_TWO;
      pair.second.symbol_char = b64_char(h1[5:0]);
      pair.second.last        = 1'b1;
      if (v0) begin
         pair.first.which_part  = PART_ONE;
         pair.first.symbol_char = b64_char(h0[5:0]);
         pair.first.last        = !v1;
      end else begin
         pair.first = pair.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fnv1_ff  <= FNV_BASIS;
         fnv2_ff  <= FNV_BASIS;
         pend1_ff <= 1'b0;
         pend2_ff <= 1'b0;
      end else if (go) begin
         fnv1_ff  <= fnv1_in;
         fnv2_ff  <= fnv2_in;
         pend1_ff <= pend1_in;
         pend2_ff <= pend2_in;
      end
   end

   // A part with nothing pending must hold a fresh hash
   a_idle_one_fresh : assert property (@(posedge clock) disable iff (reset)
      !pend1_ff |-> fnv1_ff == FNV_BASIS)
      else $error("part one idle with stale hash");

   a_idle_two_fresh : assert property (@(posedge clock) disable iff (reset)
      !pend2_ff |-> fnv2_ff == FNV_BASIS)
      else $error("part two idle with stale hash");

   // An end word leaves both parts cleared
   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      go && word.mode == MODE_END |=> !pend1_ff && !pend2_ff)
      else $error("end word did not clear pending parts");

endmodule

[rtl/pfh_out_buf.sv]
// Output buffer: holds the one or two result words of an item and drives
// the result channel. Depends on pfh_pkg and pfh_rsp_if.
module pfh_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  pfh_pkg::result_pair_type pair,
   output logic                     can_load,
   pfh_rsp_if.source                rsp_chan
);
   import pfh_pkg::*;

   logic [1:0]    cnt_ff, cnt_in;
   rsp_entry_type slot0_ff, slot0_in;
   rsp_entry_type slot1_ff, slot1_in;
   logic          pop;

   // Pop from slot 0; slot 1 moves up behind it
   always_comb begin
      pop      = (cnt_ff != 2'd0) && rsp_chan.ready;
      can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_chan.ready);
      if (load) begin
         cnt_in   = pair.count;
         slot0_in = pair.first;
         slot1_in = pair.second;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
         slot1_in = slot1_ff;
      end else begin
         cnt_in   = cnt_ff;
         slot0_in = slot0_ff;
         slot1_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.which_part  = slot0_ff.which_part;
   assign rsp_chan.symbol_char = slot0_ff.symbol_char;
   assign rsp_chan.last        = slot0_ff.last;

   // Never more than the two words one item can give
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer overfilled");

   // With two words held, only the second closes the item
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> slot1_ff.last && !slot0_ff.last)
      else $error("last flag misplaced in output pair");

endmodule

[tb/pfh_signature_checker.sv]
`timescale 1ns / 1ps
// Signature checker for the fuzzy hash engine. It watches the request, result
// and register ports, predicts every signature character and compares it.
// Depends on pfh_pkg, pfh_req_if and pfh_rsp_if.
module pfh_signature_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  pfh_pkg::shift_type csr_write_data,
   pfh_req_if                 req_mon,
   pfh_rsp_if                 rsp_mon,
   output int                 chars_outstanding,
   output int                 mismatch_count
);
   import pfh_pkg::*;

   // Signature alphabet, first character in the top byte
   localparam logic [8*64-1:0] SIG_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int PRINT_CAP = 40;

   // Predicted engine state
   shift_type     block_shift_q;
   logic [31:0]   plain_sum;
   logic [31:0]   ramp_sum;
   logic [31:0]   xor_mix;
   logic [7:0]    recent_bytes [WINDOW_LEN];
   int unsigned   recent_slot;
   logic [31:0]   fnv_one;
   logic [31:0]   fnv_two;
   bit            one_open;
   bit            two_open;

   rsp_entry_type expected_chars [$];
   int            errors;
   int            printed;

   assign mismatch_count = errors;

   initial begin
      errors  = 0;
      printed = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (printed < PRINT_CAP) begin
         $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
         printed++;
      end
      errors++;
   endtask

   task automatic clear_hashes();
      plain_sum   = '0;
      ramp_sum    = '0;
      xor_mix     = '0;
      recent_slot = 0;
      fnv_one     = FNV_BASIS;
      fnv_two     = FNV_BASIS;
      one_open    = 1'b0;
      two_open    = 1'b0;
      foreach (recent_bytes[i]) recent_bytes[i] = 8'd0;
   endtask

   function automatic rsp_entry_type make_char(input logic part, input logic [31:0] hash);
      rsp_entry_type c;
      c.which_part  = part;
      c.symbol_char = SIG_ALPHABET[8*(63 - int'(hash[5:0])) +: 7];
      c.last        = 1'b0;
      return c;
   endfunction

   // Advance the hashes by one word and queue the characters it gives
   task automatic absorb_word(input logic m, input logic [7:0] b);
      logic [63:0]   blk;
      logic [63:0]   roll;
      logic [31:0]   wide_b;
      rsp_entry_type made [2];
      int            n;
      n      = 0;
      wide_b = {24'd0, b};
      if (m == MODE_DATA) begin
         blk         = 64'd3 << block_shift_q;
         ramp_sum    = ramp_sum - plain_sum + 32'(WINDOW_LEN) * wide_b;
         plain_sum   = plain_sum + wide_b - {24'd0, recent_bytes[recent_slot]};
         recent_bytes[recent_slot] = b;
         recent_slot = (recent_slot + 1) % WINDOW_LEN;
         xor_mix     = (xor_mix << XOR_SHIFT) ^ wide_b;
         fnv_one     = (fnv_one * FNV_MULT) ^ wide_b;
         fnv_two     = (fnv_two * FNV_MULT) ^ wide_b;
         one_open    = 1'b1;
         two_open    = 1'b1;
         roll        = {32'd0, 32'(plain_sum + ramp_sum + xor_mix)};
         // block boundary for part one
         if (roll % blk == blk - 64'd1) begin
            made[n] = make_char(PART_ONE, fnv_one);
            n++;
            fnv_one  = FNV_BASIS;
            one_open = 1'b0;
         end
         // double-size boundary for part two
         if (roll % (blk << 1) == (blk << 1) - 64'd1) begin
            made[n] = make_char(PART_TWO, fnv_two);
            n++;
            fnv_two  = FNV_BASIS;
            two_open = 1'b0;
         end
      end else begin
         // end of file: flush what is open, then start afresh
         if (one_open) begin
            made[n] = make_char(PART_ONE, fnv_one);
            n++;
         end
         if (two_open) begin
            made[n] = make_char(PART_TWO, fnv_two);
            n++;
         end
         clear_hashes();
      end
      if (n > 0) made[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_chars.push_back(made[i]);
   endtask

   // Results are checked before new words are absorbed: a word cannot
   // produce a character on the edge it is accepted.
   always @(posedge clock) begin : watch
      rsp_entry_type want;
      if (reset) begin
         block_shift_q = '0;
         clear_hashes();
         expected_chars.delete();
      end else begin
         if (csr_write_enable === 1'b1) block_shift_q = csr_write_data;
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("result word with nothing expected",
                               int'(rsp_mon.symbol_char), 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_mon.which_part !== want.which_part)
                  report_mismatch("which_part", int'(rsp_mon.which_part),
                                  int'(want.which_part));
               if (rsp_mon.symbol_char !== want.symbol_char)
                  report_mismatch("symbol_char", int'(rsp_mon.symbol_char),
                                  int'(want.symbol_char));
               if (rsp_mon.last !== want.last)
                  report_mismatch("last", int'(rsp_mon.last), int'(want.last));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            absorb_word(req_mon.mode, req_mon.data_byte);
      end
      chars_outstanding <= expected_chars.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the fuzzy hash engine testbench: clock, reset, file-byte stimulus,
// result back-pressure and the verdict. Depends on pfh_pkg, the channel
// interfaces, pfh_signature_checker and piecewise_fuzzy_hash_engine_core.
module tb;
   import pfh_pkg::*;

   localparam int TARGET_ITEMS  = 450;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 120;
   localparam int HOLD_PHASE    = 2;
   localparam logic [7:0] CORNER_BYTES [12] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h02,
                                                8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};

   logic      clock;
   logic      reset;
   logic      csr_write_enable;
   shift_type csr_write_data;
   logic      hold_results;
   int        chars_outstanding;
   int        mismatch_count;
   int        words_sent;
   bit        gaps_on;

   pfh_req_if req_bus ();
   pfh_rsp_if rsp_bus ();

   piecewise_fuzzy_hash_engine_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   pfh_signature_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .chars_outstanding (chars_outstanding),
      .mismatch_count    (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #(4_000_000);
      $display("FAIL piecewise_fuzzy_hash_engine_core");
      $finish;
   end

   // Offer one word and hold it until taken, then maybe leave a gap
   task automatic send_word(input logic m, input logic [7:0] b);
      int r;
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= m;
      req_bus.data_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      words_sent++;
      if (gaps_on) begin
         r   = $urandom_range(0, 99);
         gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // A run of file bytes in one of a few flavours
   task automatic send_file(input int len);
      int flavour;
      logic [7:0] run_byte;
      flavour  = $urandom_range(0, 9);
      run_byte = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         if (flavour < 6)      send_word(MODE_DATA, 8'($urandom));
         else if (flavour < 9) send_word(MODE_DATA, 8'($urandom_range(32, 126)));
         else                  send_word(MODE_DATA, run_byte);
      end
   endtask

   // Stop offering and wait for every character, plus the pipeline depth
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (chars_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_block_shift(input shift_type v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Word stimulus
   initial begin : stimulus
      int        r;
      int        len;
      int        phase;
      shift_type sh;
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.mode      <= MODE_DATA;
      req_bus.data_byte <= 8'd0;
      hold_results      <= 1'b0;
      gaps_on    = 1'b1;
      words_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: end with nothing open, corner bytes past a window wrap,
      // end carrying a stray data byte, then an end with nothing open again
      send_word(MODE_END, 8'h00);
      foreach (CORNER_BYTES[i]) send_word(MODE_DATA, CORNER_BYTES[i]);
      send_word(MODE_END, 8'hA5);
      send_word(MODE_END, 8'hFF);
      wait_drained();

      // Block shift 30: part two only comes out of the flush
      set_block_shift(5'd30);
      send_word(MODE_DATA, 8'hFF);
      send_word(MODE_DATA, 8'h00);
      send_word(MODE_DATA, 8'hFF);
      send_word(MODE_END, 8'h5A);

      // Random phases of well-formed files, with some noise in between
      phase = 0;
      while (words_sent < TARGET_ITEMS) begin
         wait_drained();
         r = $urandom_range(0, 99);
         // smallest block size where the result side must back up
         if (phase == 0 || phase == HOLD_PHASE) sh = 5'd0;
         else if (r < 65)  sh = 5'($urandom_range(0, 3));
         else if (r < 85)  sh = 5'($urandom_range(4, 29));
         else              sh = 5'd30;
         set_block_shift(sh);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) begin
            // back-to-back words while the result side holds off
            gaps_on = 1'b0;
            hold_results <= 1'b1;
            send_file(40);
         end
         repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 25);
            send_file(len);
            r = $urandom_range(0, 99);
            if (r < 85) begin
               send_word(MODE_END, 8'($urandom));
            end else if (r < 93) begin
               send_word(MODE_END, 8'($urandom));
               send_word(MODE_END, 8'($urandom));
            end
            // otherwise the file runs on into the next one
         end
         phase++;
      end
      wait_drained();

      if (mismatch_count == 0) begin
         $display("PASS piecewise_fuzzy_hash_engine_core");
      end else begin
         $display("FAIL piecewise_fuzzy_hash_engine_core");
      end
      $finish;
   end

   // Result side: random stalls, steady stretches and one long hold-off
   initial begin : result_sink
      int r;
      int len;
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!hold_done && hold_results === 1'b1) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_bus.ready <= 1'b1;
               len = $urandom_range(1, 8);
            end else if (r < 72) begin
               rsp_bus.ready <= 1'b1;
               len = $urandom_range(20, 60);
            end else if (r < 95) begin
               rsp_bus.ready <= 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               rsp_bus.ready <= 1'b0;
               len = $urandom_range(10, 30);
            end
            // cut the stretch short once the long hold-off is asked for
            for (int i = 0; i < len; i++) begin
               @(posedge clock);
               if (!hold_done && hold_results === 1'b1) break;
            end
         end
      end
   end

endmodule
